>>> rtl/core/row_argsort_engine_top_defines.svh
// Assertion macros for the row argsort engine checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ROW_ARGSORT_ENGINE_TOP_DEFINES_SVH
`define ROW_ARGSORT_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RAE_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rae_pkg.sv
// Shared constants, types and state codes of the row argsort engine.
// Depends on nothing; every module of the engine imports it.
package rae_pkg;

    localparam int ROW_MAX        = 64;
    localparam int CELL_IDX_W     = $clog2(ROW_MAX);
    localparam int CNT_W          = $clog2(ROW_MAX + 1);
    localparam int VALUE_W        = 64;
    localparam int KEY_W          = 64;
    localparam int SORTED_INDEX_W = 6;
    localparam int TYPE_W         = 3;
    localparam int ROW_LEN_W      = 7;
    localparam int APB_ADDR_W     = 4;
    localparam int APB_DATA_W     = 32;
    localparam int REG_IDX_W      = APB_ADDR_W - 2;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int OUTQ_DEPTH     = 2;
    localparam int OPTR_W         = $clog2(OUTQ_DEPTH);
    localparam int OCNT_W         = $clog2(OUTQ_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_ELEMENT_TYPE    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SORT_DESCENDING = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_LENGTH      = 2'd2;

    // Element type codes; the two remaining codes use the raw word as key.
    localparam logic [TYPE_W-1:0] ELEM_F32  = 3'd0;
    localparam logic [TYPE_W-1:0] ELEM_F64  = 3'd1;
    localparam logic [TYPE_W-1:0] ELEM_I32  = 3'd2;
    localparam logic [TYPE_W-1:0] ELEM_I64  = 3'd3;
    localparam logic [TYPE_W-1:0] ELEM_F16  = 3'd4;
    localparam logic [TYPE_W-1:0] ELEM_BF16 = 3'd5;

    localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = ROW_LEN_W'(ROW_MAX);

    // One classified element on its way from the front to the back.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             row_end;
        logic             descending;
    } rae_item_t;

    // Commands from the back controller to both cell chains.
    typedef struct packed {
        logic             insert;
        logic             shift;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } rae_chain_ctl_t;

    typedef struct packed {
        logic [SORTED_INDEX_W-1:0] index;
        logic                      last;
    } rae_result_t;

    typedef enum logic {
        BACK_LOAD,
        BACK_DRAIN
    } rae_back_state_t;

endpackage

>>> rtl/core/rae_front.sv
// Front end: configuration registers, key conversion and row bookkeeping.
// Depends on rae_pkg.
module rae_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rae_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rae_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rae_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           push,
    input  logic                           q_full,
    input  logic [rae_pkg::VALUE_W-1:0]    value_bits,
    output logic                           item_valid,
    output rae_pkg::rae_item_t             item
);
    import rae_pkg::*;

    logic [TYPE_W-1:0]    element_type_reg;
    logic                 sort_descending_reg;
    logic [ROW_LEN_W-1:0] row_length_reg;
    logic [CNT_W-1:0]     loaded_reg;
    logic [CNT_W-1:0]     loaded_next;
    logic [ROW_LEN_W-1:0] eff_len;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [KEY_W-1:0]     key;

    // Order-preserving key of a sign/magnitude float of the width marked by sign_bit.
    function automatic logic [KEY_W-1:0] float_key(input logic [KEY_W-1:0] bits,
                                                   input logic [KEY_W-1:0] sign_bit);
        logic [KEY_W-1:0] mask;
        logic [KEY_W-1:0] mag;
        mask = (sign_bit << 1) - KEY_W'(1);
        mag  = bits & mask;
        if (mag == sign_bit)
            mag = '0;
        if ((mag & sign_bit) != '0)
            return ~mag & mask;
        return mag | sign_bit;
    endfunction

    function automatic logic [KEY_W-1:0] int_key(input logic [KEY_W-1:0] bits,
                                                 input logic [KEY_W-1:0] sign_bit);
        logic [KEY_W-1:0] mask;
        mask = (sign_bit << 1) - KEY_W'(1);
        return (bits & mask) ^ sign_bit;
    endfunction

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_type_reg    <= ELEM_F32;
            sort_descending_reg <= 1'b0;
            row_length_reg      <= ROW_LEN_RESET;
            loaded_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_idx)
                    REG_ELEMENT_TYPE:    element_type_reg    <= pwdata[TYPE_W-1:0];
                    REG_SORT_DESCENDING: sort_descending_reg <= pwdata[0];
                    REG_ROW_LENGTH:      row_length_reg      <= pwdata[ROW_LEN_W-1:0];
                    default:             ;
                endcase
            end
            loaded_reg <= loaded_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_ELEMENT_TYPE:    prdata = APB_DATA_W'(element_type_reg);
            REG_SORT_DESCENDING: prdata = APB_DATA_W'(sort_descending_reg);
            REG_ROW_LENGTH:      prdata = APB_DATA_W'(row_length_reg);
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        case (element_type_reg)
            ELEM_F32:  key = float_key(value_bits, KEY_W'(1) << 31);
            ELEM_F64:  key = float_key(value_bits, KEY_W'(1) << 63);
            ELEM_I32:  key = int_key(value_bits, KEY_W'(1) << 31);
            ELEM_I64:  key = int_key(value_bits, KEY_W'(1) << 63);
            ELEM_F16:  key = float_key(value_bits, KEY_W'(1) << 15);
            ELEM_BF16: key = float_key(value_bits, KEY_W'(1) << 15);
            default:   key = value_bits;
        endcase
    end

    // A length of zero acts as one, anything past the cell count as the cell count.
    always_comb
    begin
        if (row_length_reg == '0)
            eff_len = ROW_LEN_W'(1);
        else if (row_length_reg > ROW_LEN_W'(ROW_MAX))
            eff_len = ROW_LEN_W'(ROW_MAX);
        else
            eff_len = row_length_reg;
    end

    always_comb
    begin
        item_valid      = push && !q_full;
        item.key        = key;
        item.row_end    = (ROW_LEN_W'(loaded_reg) + ROW_LEN_W'(1)) >= eff_len;
        item.descending = sort_descending_reg;
        loaded_next     = loaded_reg;
        if (item_valid)
            loaded_next = item.row_end ? '0 : loaded_reg + CNT_W'(1);
    end

endmodule

>>> rtl/core/rae_queue.sv
// Short request queue that decouples the front end from the sorting back end.
// Depends on rae_pkg.
module rae_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rae_pkg::rae_item_t wr_item,
    output logic               full,
    input  logic               rd_en,
    output rae_pkg::rae_item_t rd_item,
    output logic               q_empty
);
    import rae_pkg::*;

    rae_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_empty = cnt_reg == '0;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + QPTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/core/rae_chain.sv
// Insertion cell chain: keeps the row's keys sorted, one insert or shift per cycle.
// Depends on rae_pkg.
module rae_chain (
    input  logic                           clk,
    input  logic                           order_desc,
    input  rae_pkg::rae_chain_ctl_t        ctl,
    output logic [rae_pkg::CELL_IDX_W-1:0] head_pos
);
    import rae_pkg::*;

    logic [KEY_W-1:0]      key_reg   [ROW_MAX];
    logic [KEY_W-1:0]      key_next  [ROW_MAX];
    logic [KEY_W-1:0]      key_lower [ROW_MAX];
    logic [KEY_W-1:0]      key_upper [ROW_MAX];
    logic [CELL_IDX_W-1:0] pos_reg   [ROW_MAX];
    logic [CELL_IDX_W-1:0] pos_next  [ROW_MAX];
    logic [CELL_IDX_W-1:0] pos_lower [ROW_MAX];
    logic [CELL_IDX_W-1:0] pos_upper [ROW_MAX];
    logic [ROW_MAX-1:0]    stays;
    logic [ROW_MAX-1:0]    below_stays;
    logic [CELL_IDX_W-1:0] new_pos;

    assign new_pos  = ctl.count[CELL_IDX_W-1:0];
    assign head_pos = pos_reg[0];

    // A cell keeps its place when it holds an element that goes ahead of the new one.
    // Equal keys stay ahead, so ties come out in arrival order.
    always_comb
    begin
        for (int i = 0; i < ROW_MAX; i++)
        begin
            stays[i] = (CNT_W'(i) < ctl.count) &&
                       (order_desc ? (key_reg[i] >= ctl.key) : (key_reg[i] <= ctl.key));
        end
    end

    assign below_stays = {stays[ROW_MAX-2:0], 1'b1};

    always_comb
    begin
        key_lower[0]           = ctl.key;
        pos_lower[0]           = new_pos;
        key_upper[ROW_MAX-1]   = key_reg[ROW_MAX-1];
        pos_upper[ROW_MAX-1]   = pos_reg[ROW_MAX-1];
        for (int i = 1; i < ROW_MAX; i++)
        begin
            key_lower[i] = key_reg[i-1];
            pos_lower[i] = pos_reg[i-1];
        end
        for (int i = 0; i < ROW_MAX - 1; i++)
        begin
            key_upper[i] = key_reg[i+1];
            pos_upper[i] = pos_reg[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < ROW_MAX; i++)
        begin
            key_next[i] = key_reg[i];
            pos_next[i] = pos_reg[i];
            if (ctl.insert && !stays[i])
            begin
                if (below_stays[i])
                begin
                    key_next[i] = ctl.key;
                    pos_next[i] = new_pos;
                end
                else
                begin
                    key_next[i] = key_lower[i];
                    pos_next[i] = pos_lower[i];
                end
            end
            else if (ctl.shift)
            begin
                key_next[i] = key_upper[i];
                pos_next[i] = pos_upper[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

endmodule

>>> rtl/core/rae_back.sv
// Back end: loads queued elements into the cell chains and drains finished rows.
// Depends on rae_pkg; drives both rae_chain instances.
module rae_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  rae_pkg::rae_item_t                 q_item,
    output logic                               q_pop,
    output rae_pkg::rae_chain_ctl_t            ctl,
    input  logic [rae_pkg::CELL_IDX_W-1:0]     asc_head_pos,
    input  logic [rae_pkg::CELL_IDX_W-1:0]     desc_head_pos,
    output logic                               empty,
    input  logic                               pop,
    output logic [rae_pkg::SORTED_INDEX_W-1:0] sorted_index,
    output logic                               last_of_row
);
    import rae_pkg::*;

    rae_back_state_t   state_reg;
    rae_back_state_t   state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              desc_reg;
    logic              desc_next;
    rae_result_t       oq_mem_reg [OUTQ_DEPTH];
    logic [OPTR_W-1:0] oq_wr_reg;
    logic [OPTR_W-1:0] oq_rd_reg;
    logic [OCNT_W-1:0] oq_cnt_reg;
    logic [OCNT_W-1:0] oq_cnt_next;
    logic              oq_push;
    logic              oq_pop;
    rae_result_t       result;

    assign empty        = oq_cnt_reg == '0;
    assign oq_pop       = pop && !empty;
    assign sorted_index = oq_mem_reg[oq_rd_reg].index;
    assign last_of_row  = oq_mem_reg[oq_rd_reg].last;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        desc_next    = desc_reg;
        q_pop        = 1'b0;
        oq_push      = 1'b0;
        ctl.insert   = 1'b0;
        ctl.shift    = 1'b0;
        ctl.key      = q_item.key;
        ctl.count    = cnt_reg;
        result.index = SORTED_INDEX_W'(desc_reg ? desc_head_pos : asc_head_pos);
        result.last  = cnt_reg == CNT_W'(1);
        case (state_reg)
            BACK_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    ctl.insert = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    if (q_item.row_end)
                    begin
                        desc_next  = q_item.descending;
                        state_next = BACK_DRAIN;
                    end
                end
            end
            BACK_DRAIN:
            begin
                if (oq_cnt_reg != OCNT_W'(OUTQ_DEPTH))
                begin
                    oq_push   = 1'b1;
                    ctl.shift = 1'b1;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_next = BACK_LOAD;
                end
            end
            default:
            begin
                state_next = BACK_LOAD;
            end
        endcase
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (oq_push && !oq_pop)
            oq_cnt_next = oq_cnt_reg + OCNT_W'(1);
        else if (oq_pop && !oq_push)
            oq_cnt_next = oq_cnt_reg - OCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem_reg[oq_wr_reg] <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BACK_LOAD;
            cnt_reg    <= '0;
            desc_reg   <= 1'b0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            desc_reg   <= desc_next;
            oq_cnt_reg <= oq_cnt_next;
            if (oq_push)
                oq_wr_reg <= (oq_wr_reg == OPTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                     : oq_wr_reg + OPTR_W'(1);
            if (oq_pop)
                oq_rd_reg <= (oq_rd_reg == OPTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                     : oq_rd_reg + OPTR_W'(1);
        end
    end

endmodule

>>> rtl/core/row_argsort_engine_top.sv
// Row argsort engine: top level tying the front end, request queue, cell chains and back end.
// Depends on rae_pkg, rae_front, rae_queue, rae_chain and rae_back.
//
// The engine takes rows of raw element words, one element per request, and returns for
// each row the element positions in sorted order, one position per result, with
// last_of_row marking the final position of a row. Each word is read as f32, f64, i32,
// i64, f16 or bf16 according to element_type (narrower types in the low bits) and turned
// into an unsigned key whose order is the value order; both zeros compare equal and NaNs
// sort by their sign, below minus infinity or above plus infinity. Equal keys always give
// the lower position first, ascending or descending. A row ends when the number of
// elements received reaches row_length (zero acts as one, lengths past 64 act as 64).
// Every element is inserted into the sorted cell chain and every result leaves it by a
// shift. Insertion and drain share the cell chain, so a row is fully drained before the
// back end loads the next row. A four-entry request queue keeps accepting elements of the
// next row while the current row drains, and a two-entry result queue lets results wait;
// the drain stalls while that queue is full. With the back end idle, the last element of a
// row passes through the request queue, the cell chains and the result queue before the
// row's first result appears. No clearing pass is needed after reset. Configuration is
// meant to be written while the engine is idle; the sort direction of a row is the one in
// force when its last element is accepted, and each element uses the type in force when
// it arrived.
module row_argsort_engine_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rae_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rae_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rae_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               push,
    output logic                               full,
    input  logic [rae_pkg::VALUE_W-1:0]        value_bits,
    output logic                               empty,
    input  logic                               pop,
    output logic [rae_pkg::SORTED_INDEX_W-1:0] sorted_index,
    output logic                               last_of_row
);
    import rae_pkg::*;

    logic                  item_valid;
    rae_item_t             item;
    rae_item_t             q_item;
    logic                  q_empty;
    logic                  q_pop;
    rae_chain_ctl_t        ctl;
    logic [CELL_IDX_W-1:0] asc_head_pos;
    logic [CELL_IDX_W-1:0] desc_head_pos;

    // The front end converts each element to its key and decides whether it closes a row.
    rae_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .q_full     (full),
        .value_bits (value_bits),
        .item_valid (item_valid),
        .item       (item)
    );

    rae_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_valid),
        .wr_item (item),
        .full    (full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .q_empty (q_empty)
    );

    // Two chains hold the same row in both orders, so the direction can be chosen
    // when the row completes without losing the lower-position-first rule for ties.
    rae_chain u_chain_asc (
        .clk        (clk),
        .order_desc (1'b0),
        .ctl        (ctl),
        .head_pos   (asc_head_pos)
    );

    rae_chain u_chain_desc (
        .clk        (clk),
        .order_desc (1'b1),
        .ctl        (ctl),
        .head_pos   (desc_head_pos)
    );

    rae_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .ctl           (ctl),
        .asc_head_pos  (asc_head_pos),
        .desc_head_pos (desc_head_pos),
        .empty         (empty),
        .pop           (pop),
        .sorted_index  (sorted_index),
        .last_of_row   (last_of_row)
    );

endmodule

>>> rtl/core/rae_checker.sv
// Port-level checker for the row argsort engine, bound to its top level.
// Depends on rae_pkg and row_argsort_engine_top_defines.svh.
`include "row_argsort_engine_top_defines.svh"

module rae_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               psel,
    input logic                               pready,
    input logic                               push,
    input logic                               full,
    input logic                               empty,
    input logic                               pop,
    input logic [rae_pkg::SORTED_INDEX_W-1:0] sorted_index,
    input logic                               last_of_row
);
    import rae_pkg::*;

    localparam int PEND_W = $clog2(ROW_MAX + QUEUE_DEPTH + OUTQ_DEPTH + 1) + 1;

    logic                           in_acc;
    logic                           out_acc;
    logic [PEND_W-1:0]              pending_reg;
    logic [(1 << SORTED_INDEX_W)-1:0] seen_reg;
    logic [(1 << SORTED_INDEX_W)-1:0] seen_next;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_comb
    begin
        seen_next = seen_reg;
        if (out_acc)
        begin
            seen_next[sorted_index] = 1'b1;
            if (last_of_row)
                seen_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            seen_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + PEND_W'(in_acc) - PEND_W'(out_acc);
            seen_reg    <= seen_next;
        end
    end

    // A waiting result must hold still until it is taken.
    `RAE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(sorted_index) && $stable(last_of_row), "result changed while waiting")
    // Every result stands for an element that was accepted and not yet answered.
    `RAE_ASSERT_HOLD(a_no_orphan_result, !empty, pending_reg != '0, "result without accepted element")
    // A position appears at most once within one row.
    `RAE_ASSERT_HOLD(a_index_once, out_acc, !seen_reg[sorted_index], "position repeated within a row")
    `RAE_ASSERT_HOLD(a_pready_high, psel, pready, "configuration port not ready")

endmodule

bind row_argsort_engine_top rae_checker u_rae_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .pready       (pready),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .sorted_index (sorted_index),
    .last_of_row  (last_of_row)
);
